@@ design/tvf_pkg.sv @@
// Shared types and constants for the voxel fusion block.
`default_nettype none
package tvf_pkg;

   typedef enum logic [1:0] {
      KIND_INTEGRATE = 2'd0,
      KIND_MARK_FREE = 2'd1,
      KIND_PURGE     = 2'd2,
      KIND_UNUSED    = 2'd3
   } kind_type;

   localparam int DIST_W   = 28;
   localparam int WEIGHT_W = 32;
   localparam int FREE_W   = 16;
   localparam int COORD_W  = 6;

   localparam logic [DIST_W-1:0]   PURGE_DISTANCE = 28'd65536000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_TOP     = 32'hFFFF_FFFF;
   localparam logic [FREE_W-1:0]   FREE_TOP       = 16'hFFFF;

   // Operation handed from the front end to the back end.
   typedef struct packed {
      kind_type                  kind;
      logic [COORD_W-1:0]        x;
      logic [COORD_W-1:0]        y;
      logic [COORD_W-1:0]        z;
      logic signed [DIST_W-1:0]  sdist;
   } op_type;

endpackage
`default_nettype wire

@@ design/tvf_front.sv @@
// Front end: accepts transactions, drops out-of-grid and unused kinds, queues the rest.
`default_nettype none
module tvf_front #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64,
   parameter int GRID_Z = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire tvf_pkg::op_type in_op,
   output logic                 op_valid,
   input  wire logic            op_ready,
   output tvf_pkg::op_type      op_data
);

   localparam int DEPTH = 4;

   tvf_pkg::op_type fifo_ff [DEPTH];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;
   logic       keep, push, pop;

   // Keep integrate/mark-free inside the grid and purge; drop everything else.
   always_comb begin
      keep = 1'b0;
      unique case (in_op.kind)
         tvf_pkg::KIND_PURGE:
            keep = 1'b1;
         tvf_pkg::KIND_INTEGRATE, tvf_pkg::KIND_MARK_FREE:
            keep = (32'(in_op.x) < 32'(GRID_X)) && (32'(in_op.y) < 32'(GRID_Y))
                && (32'(in_op.z) < 32'(GRID_Z));
         default:
            keep = 1'b0;
      endcase
   end

   assign in_ready = (count_ff != 3'(DEPTH));
   assign push     = in_valid && in_ready && keep;
   assign op_valid = (count_ff != 3'd0);
   assign pop      = op_valid && op_ready;
   assign op_data  = fifo_ff[rd_ptr_ff];

   // Small op queue between front and back end
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + 3'(push) - 3'(pop);
      end
      if (push) fifo_ff[wr_ptr_ff] <= in_op;
   end

endmodule
`default_nettype wire

@@ design/tvf_divider.sv @@
// Restoring divider, one quotient bit per cycle; round-to-nearest comes from the caller pre-biasing the numerator.
`default_nettype none
module tvf_divider #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 34
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   shifted;

   // One shift-subtract step; any pre-bias of the numerator is done by the caller
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DEN_W-1:0], quot_ff[NUM_W-1]};
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in  = shifted - {1'b0, den_ff};
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (start) den_ff <= denom;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

@@ design/tvf_back.sv @@
// Back end: voxel memories, clearing pass, integrate/mark-free/purge sequencer.
`default_nettype none
module tvf_back #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64,
   parameter int GRID_Z = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            op_valid,
   output logic                 op_ready,
   input  wire tvf_pkg::op_type op_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output logic [tvf_pkg::DIST_W-1:0]   out_dist,
   output logic [tvf_pkg::WEIGHT_W-1:0] out_weight,
   output logic [tvf_pkg::FREE_W-1:0]   out_free
);

   localparam int VOXELS = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W = $clog2(VOXELS);
   localparam int DW = tvf_pkg::DIST_W;
   localparam int WW = tvf_pkg::WEIGHT_W;
   localparam int FW = tvf_pkg::FREE_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_ADDR1, ST_ADDR2, ST_READ, ST_SQ, ST_DEN,
      ST_WDIV, ST_MUL, ST_SUM, ST_ADIV, ST_WRITE, ST_OUT,
      ST_PREAD, ST_PWAIT, ST_PTEST
   } state_type;

   state_type state_ff;

   // Voxel memories, one write and one read port each
   logic [DW-1:0] dist_mem   [VOXELS];
   logic [WW-1:0] weight_mem [VOXELS];
   logic [FW-1:0] free_mem   [VOXELS];

   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [DW-1:0]     dist_rd_ff, dist_wr;
   logic [WW-1:0]     weight_rd_ff, weight_wr;
   logic [FW-1:0]     free_rd_ff, free_wr;
   logic              we_dist, we_weight, we_free;

   always_ff @(posedge clock) begin
      if (we_dist)   dist_mem[wr_addr]   <= dist_wr;
      if (we_weight) weight_mem[wr_addr] <= weight_wr;
      if (we_free)   free_mem[wr_addr]   <= free_wr;
      dist_rd_ff   <= dist_mem[rd_addr];
      weight_rd_ff <= weight_mem[rd_addr];
      free_rd_ff   <= free_mem[rd_addr];
   end

   // Working registers
   tvf_pkg::kind_type kind_ff;
   logic [ADDR_W-1:0] addr_ff, sweep_ff;
   logic [ADDR_W-1:0] xy_ff;
   logic signed [DW-1:0] samp_ff;
   logic [DW-1:0]     mag_ff;
   logic [55:0]       sq_ff;
   logic [59:0]       den_ff;
   logic [16:0]       w_ff;
   logic signed [DW-1:0] odist_ff;
   logic [WW-1:0]     oweight_ff;
   logic signed [60:0] p1_ff, p2_ff;
   logic [WW:0]       sumw_ff;
   logic              neg_ff;
   logic [63:0]       mag64_ff;
   logic              pv_ff;
   logic [DW-1:0]     res_dist_ff;
   logic [WW-1:0]     res_weight_ff;
   logic [FW-1:0]     res_free_ff;
   logic              out_valid_ff;

   // Divider shared by the weight reciprocal and the average
   logic        div_start, div_done;
   logic [63:0] div_num, div_quot;
   logic [63:0] div_den_full;
   logic [49:0] div_den;

   tvf_divider #(.NUM_W(64), .DEN_W(50)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(div_num), .denom(div_den), .done(div_done), .quot(div_quot)
   );

   // At 2^50 and above the reciprocal divisor makes the weight round to 0
   logic den_big;
   assign den_big = |den_ff[59:50];

   always_comb begin
      div_start    = 1'b0;
      div_num      = '0;
      div_den_full = '0;
      if (state_ff == ST_DEN && !den_big) begin
         div_start    = 1'b1;
         div_den_full = {14'd0, den_ff[49:0]};
         div_num      = 64'h0001_0000_0000_0000 + {15'd0, den_ff[49:1]};
      end else if (state_ff == ST_SUM && sumw_ff != '0) begin
         div_start    = 1'b1;
         div_den_full = {31'd0, sumw_ff};
         div_num      = mag64_ff + {32'd0, sumw_ff[WW:1]};
      end
   end
   assign div_den = div_den_full[49:0];

   // Memory port control
   always_comb begin
      rd_addr   = addr_ff;
      wr_addr   = addr_ff;
      we_dist   = 1'b0;
      we_weight = 1'b0;
      we_free   = 1'b0;
      dist_wr   = res_dist_ff;
      weight_wr = res_weight_ff;
      free_wr   = res_free_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_addr = sweep_ff;
            we_dist = 1'b1; we_weight = 1'b1; we_free = 1'b1;
            dist_wr = '0; weight_wr = '0; free_wr = '0;
         end
         ST_PREAD: rd_addr = sweep_ff;
         // first voxel read lands in the first test cycle
         ST_PWAIT: rd_addr = addr_ff;
         ST_PTEST: begin
            rd_addr = sweep_ff;
            wr_addr = addr_ff;
            dist_wr = tvf_pkg::PURGE_DISTANCE;
            we_dist = pv_ff && ({16'd0, free_rd_ff, 16'd0} > {16'd0, weight_rd_ff});
         end
         ST_WRITE: begin
            we_dist = 1'b1; we_weight = 1'b1; we_free = 1'b1;
         end
         default: ;
      endcase
   end

   logic [60:0] num61;
   assign num61 = 61'(p1_ff + p2_ff);

   assign op_ready = (state_ff == ST_IDLE) && !out_valid_ff;

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         out_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               sweep_ff <= sweep_ff + ADDR_W'(1);
               if (32'(sweep_ff) == VOXELS - 1) begin
                  sweep_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: if (op_valid && op_ready) begin
               kind_ff <= op_data.kind;
               samp_ff <= op_data.sdist;
               mag_ff  <= op_data.sdist[DW-1] ? DW'(-op_data.sdist) : op_data.sdist;
               xy_ff   <= ADDR_W'(32'(op_data.x) * GRID_Y + 32'(op_data.y));
               addr_ff <= ADDR_W'(op_data.z);
               if (op_data.kind == tvf_pkg::KIND_PURGE) begin
                  sweep_ff <= '0;
                  pv_ff    <= 1'b0;
                  state_ff <= ST_PREAD;
               end else begin
                  state_ff <= ST_ADDR1;
               end
            end
            ST_ADDR1: begin
               addr_ff  <= ADDR_W'(32'(xy_ff) * GRID_Z + 32'(addr_ff));
               state_ff <= ST_ADDR2;
            end
            ST_ADDR2: state_ff <= ST_READ;
            ST_READ: begin
               odist_ff   <= dist_rd_ff;
               oweight_ff <= weight_rd_ff;
               res_free_ff <= free_rd_ff;
               res_dist_ff <= dist_rd_ff;
               res_weight_ff <= weight_rd_ff;
               if (kind_ff == tvf_pkg::KIND_MARK_FREE) begin
                  if (free_rd_ff != tvf_pkg::FREE_TOP)
                     res_free_ff <= free_rd_ff + FW'(1);
                  state_ff <= ST_WRITE;
               end else begin
                  sq_ff    <= 56'(mag_ff) * 56'(mag_ff);
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               den_ff   <= 60'h1_0000_0000 + 60'(sq_ff) * 60'd10;
               state_ff <= ST_DEN;
            end
            ST_DEN: begin
               if (den_big) begin
                  w_ff     <= '0;
                  state_ff <= ST_MUL;
               end else begin
                  state_ff <= ST_WDIV;
               end
            end
            ST_WDIV: if (div_done) begin
               w_ff     <= div_quot[16:0];
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               p1_ff    <= 61'(odist_ff) * $signed({29'd0, oweight_ff});
               p2_ff    <= 61'(samp_ff) * $signed({44'd0, w_ff});
               sumw_ff  <= {1'b0, oweight_ff} + 33'(w_ff);
               state_ff <= ST_SUM;
               pv_ff    <= 1'b0;
            end
            ST_SUM: begin
               if (!pv_ff) begin
                  neg_ff   <= num61[60];
                  mag64_ff <= num61[60] ? 64'(-$signed(num61)) : 64'(num61);
                  pv_ff    <= 1'b1;
               end else begin
                  res_weight_ff <= sumw_ff[WW] ? tvf_pkg::WEIGHT_TOP : sumw_ff[WW-1:0];
                  pv_ff <= 1'b0;
                  if (sumw_ff == '0) begin
                     res_dist_ff <= samp_ff;
                     state_ff    <= ST_WRITE;
                  end else begin
                     state_ff <= ST_ADIV;
                  end
               end
            end
            ST_ADIV: if (div_done) begin
               res_dist_ff <= neg_ff ? DW'(-div_quot[DW-1:0]) : div_quot[DW-1:0];
               state_ff    <= ST_WRITE;
            end
            ST_WRITE: state_ff <= ST_OUT;
            ST_OUT: begin
               out_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            // Purge sweep: read pipeline, test one voxel per cycle
            ST_PREAD: begin
               sweep_ff <= sweep_ff + ADDR_W'(1);
               addr_ff  <= sweep_ff;
               state_ff <= ST_PWAIT;
            end
            ST_PWAIT: begin
               pv_ff    <= 1'b1;
               state_ff <= ST_PTEST;
            end
            ST_PTEST: begin
               addr_ff  <= addr_ff + ADDR_W'(1);
               sweep_ff <= sweep_ff + ADDR_W'(1);
               if (32'(addr_ff) == VOXELS - 1) begin
                  sweep_ff <= '0;
                  pv_ff    <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_dist   = res_dist_ff;
   assign out_weight = res_weight_ff;
   assign out_free   = res_free_ff;

endmodule
`default_nettype wire

@@ design/tsdf_voxel_fusion.sv @@
// Top level of the signed-distance voxel fusion store.
`default_nettype none
// Voxel store for distance fusion. After reset a clearing pass writes every
// voxel to zero, one per cycle, before the back end takes the first
// transaction. A four-deep queue accepts transactions in front; the
// back end handles one at a time. Integrate uses the bit-serial divider
// for the weight reciprocal and for the average; mark-free does not use it.
// Purge sweeps every voxel, one per cycle, and returns nothing; out-of-grid
// and unused kinds are dropped at once.
module tsdf_voxel_fusion #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64,
   parameter int GRID_Z = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // voxel_x, voxel_y, voxel_z, sample_distance
   input  wire logic [1:0]  req_tuser,  // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata   // fused_distance, fused_weight, free_count, pad
);

   tvf_pkg::op_type in_op, op_data;
   logic            op_valid, op_ready;
   logic [tvf_pkg::DIST_W-1:0]   out_dist;
   logic [tvf_pkg::WEIGHT_W-1:0] out_weight;
   logic [tvf_pkg::FREE_W-1:0]   out_free;

   assign in_op.kind  = tvf_pkg::kind_type'(req_tuser);
   assign in_op.x     = req_tdata[5:0];
   assign in_op.y     = req_tdata[11:6];
   assign in_op.z     = req_tdata[17:12];
   assign in_op.sdist = req_tdata[45:18];

   tvf_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_op(in_op),
      .op_valid(op_valid), .op_ready(op_ready), .op_data(op_data)
   );

   tvf_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_back (
      .clock(clock), .reset(reset),
      .op_valid(op_valid), .op_ready(op_ready), .op_data(op_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_dist(out_dist), .out_weight(out_weight), .out_free(out_free)
   );

   assign rsp_tdata = {4'd0, out_free, out_weight, out_dist};

endmodule
`default_nettype wire
